// ----- hw/rtl/ntps_pkg.sv -----
// Shared types, command codes and helpers for the neighbor table.
`timescale 1ns / 1ps
package ntps_pkg;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_DEL = 3'd1;
    localparam logic [2:0] CMD_FIND = 3'd2;
    localparam logic [2:0] CMD_UPD = 3'd3;
    localparam logic [2:0] CMD_CLR = 3'd4;
    localparam logic [2:0] CMD_SEL = 3'd5;
    localparam logic [2:0] CMD_GET = 3'd6;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [63:0] dodag_hi;
        logic [63:0] dodag_lo;
        logic [7:0]  dtsn_in;
        logic [15:0] rank_in;
        logic [7:0]  iface_in;
        logic        reachable_in;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] res_addr_hi;
        logic [63:0] res_addr_lo;
        logic [63:0] res_dodag_hi;
        logic [63:0] res_dodag_lo;
        logic [15:0] res_rank;
        logic [7:0]  res_dtsn;
        logic [7:0]  res_iface;
        logic        res_reachable;
    } t_out;

    typedef struct packed {
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [63:0] dodag_hi;
        logic [63:0] dodag_lo;
        logic [15:0] rank;
        logic [7:0]  dtsn;
        logic [7:0]  iface;
        logic        reach;
    } t_entry;

    function automatic t_out f_res(input t_entry e);
        t_out r;
        r.status        = ST_OK;
        r.res_addr_hi   = e.addr_hi;
        r.res_addr_lo   = e.addr_lo;
        r.res_dodag_hi  = e.dodag_hi;
        r.res_dodag_lo  = e.dodag_lo;
        r.res_rank      = e.rank;
        r.res_dtsn      = e.dtsn;
        r.res_iface     = e.iface;
        r.res_reachable = e.reach;
        return r;
    endfunction

    function automatic t_out f_stat(input logic [1:0] st);
        t_out r;
        r = '0;
        r.status = st;
        return r;
    endfunction

endpackage

// ----- hw/rtl/ntps_mem.sv -----
// Entry memory in list order: one write port, two registered read ports.
`timescale 1ns / 1ps
module ntps_mem #(
    parameter int ENTRIES = 16,
    parameter int IW = $clog2(ENTRIES)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [IW-1:0]         i_waddr,
    input  ntps_pkg::t_entry      i_wdata,
    input  logic [IW-1:0]         i_raddr_a,
    input  logic [IW-1:0]         i_raddr_b,
    output ntps_pkg::t_entry      o_rdata_a,
    output ntps_pkg::t_entry      o_rdata_b
);
    ntps_pkg::t_entry r_mem [ENTRIES];
    ntps_pkg::t_entry r_rd_a;
    ntps_pkg::t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;
endmodule

// ----- hw/rtl/ntps_seq.sv -----
// Command sequencer: scans, bubble sort passes, delete shift, parent tracking.
`timescale 1ns / 1ps
module ntps_seq #(
    parameter int ENTRIES = 16,
    parameter int IW = $clog2(ENTRIES),
    parameter int CW = $clog2(ENTRIES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  ntps_pkg::t_in         i_data,
    input  logic                  i_take,
    output logic                  o_done,
    output ntps_pkg::t_out        o_res,
    output logic                  o_we,
    output logic [IW-1:0]         o_waddr,
    output ntps_pkg::t_entry      o_wdata,
    output logic [IW-1:0]         o_raddr_a,
    output logic [IW-1:0]         o_raddr_b,
    input  ntps_pkg::t_entry      i_rdata_a,
    input  ntps_pkg::t_entry      i_rdata_b
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SC_RD = 11'b00000000010,
        S_SC_CK = 11'b00000000100,
        S_SO_RD = 11'b00000001000,
        S_SO_CK = 11'b00000010000,
        S_SO_WR = 11'b00000100000,
        S_DL_RD = 11'b00001000000,
        S_DL_WR = 11'b00010000000,
        S_PR_RD = 11'b00100000000,
        S_PR_CK = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    t_state            r_state, n_state;
    ntps_pkg::t_in     r_in, n_in;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [IW-1:0]     r_p, n_p;
    logic              r_swap, n_swap;
    logic              r_par_v, n_par_v;
    logic [IW-1:0]     r_par, n_par;
    ntps_pkg::t_out    r_res, n_res;
    ntps_pkg::t_entry  r_tmp, n_tmp;

    logic [IW-1:0]     w_p1;
    logic [CW:0]       w_p1c, w_p2c, w_cntc;
    logic              w_hit;
    logic              w_more;
    ntps_pkg::t_entry  w_upd;

    assign w_p1   = r_p + 1'b1;
    assign w_p1c  = (CW+1)'(r_p) + (CW+1)'(1);
    assign w_p2c  = (CW+1)'(r_p) + (CW+1)'(2);
    assign w_cntc = (CW+1)'(r_cnt);

    always_comb begin
        if (r_in.cmd == ntps_pkg::CMD_SEL) begin
            w_hit = i_rdata_a.reach && (i_rdata_a.rank < r_in.rank_in);
        end else begin
            w_hit = (i_rdata_a.addr_hi == r_in.addr_hi) &&
                    (i_rdata_a.addr_lo == r_in.addr_lo);
        end
        w_upd          = i_rdata_a;
        w_upd.dodag_hi = r_in.dodag_hi;
        w_upd.dodag_lo = r_in.dodag_lo;
        w_upd.rank     = r_in.rank_in;
        w_upd.dtsn     = r_in.dtsn_in;
        w_upd.iface    = r_in.iface_in;
    end

    assign o_stall   = (r_state != S_IDLE);
    assign o_done    = (r_state == S_DONE) && i_take;
    assign o_res     = r_res;
    assign o_raddr_a = (r_state == S_DL_RD) ? w_p1 : ((r_state == S_PR_RD) ? r_par : r_p);
    assign o_raddr_b = w_p1;

    always_comb begin
        n_state = r_state;
        n_in    = r_in;
        n_cnt   = r_cnt;
        n_p     = r_p;
        n_swap  = r_swap;
        n_par_v = r_par_v;
        n_par   = r_par;
        n_res   = r_res;
        n_tmp   = r_tmp;
        o_we    = 1'b0;
        o_waddr = r_p;
        o_wdata = i_rdata_a;
        w_more  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in  = i_data;
                    n_p   = '0;
                    n_swap = 1'b0;
                    n_state = S_DONE;
                    n_res = ntps_pkg::f_stat(ntps_pkg::ST_MISS);
                    case (i_data.cmd)
                        ntps_pkg::CMD_ADD: begin
                            if (r_cnt == FULL_CNT) begin
                                n_res = ntps_pkg::f_stat(ntps_pkg::ST_FULL);
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = r_cnt[IW-1:0];
                                o_wdata = '{addr_hi: i_data.addr_hi, addr_lo: i_data.addr_lo,
                                            dodag_hi: i_data.dodag_hi,
                                            dodag_lo: i_data.dodag_lo,
                                            rank: i_data.rank_in, dtsn: i_data.dtsn_in,
                                            iface: i_data.iface_in,
                                            reach: i_data.reachable_in};
                                n_cnt = r_cnt + 1'b1;
                                if (r_cnt != '0) begin
                                    n_state = S_SO_RD;
                                end else begin
                                    n_res = ntps_pkg::f_stat(ntps_pkg::ST_OK);
                                end
                            end
                        end
                        ntps_pkg::CMD_DEL, ntps_pkg::CMD_FIND, ntps_pkg::CMD_UPD: begin
                            if (r_cnt != '0) n_state = S_SC_RD;
                        end
                        ntps_pkg::CMD_CLR: begin
                            n_cnt   = '0;
                            n_par_v = 1'b0;
                            n_par   = '0;
                            n_res   = ntps_pkg::f_stat(ntps_pkg::ST_OK);
                        end
                        ntps_pkg::CMD_SEL: begin
                            if (r_cnt > CW'(1)) begin
                                n_state = S_SO_RD;
                            end else if (r_cnt == CW'(1)) begin
                                n_state = S_SC_RD;
                            end else begin
                                n_par_v = 1'b0;
                                n_par   = '0;
                            end
                        end
                        ntps_pkg::CMD_GET: begin
                            if (r_par_v) n_state = S_PR_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SC_RD: n_state = S_SC_CK;
            S_SC_CK: begin
                if (w_hit) begin
                    n_state = S_DONE;
                    case (r_in.cmd)
                        ntps_pkg::CMD_UPD: begin
                            o_we    = 1'b1;
                            o_wdata = w_upd;
                            n_res   = ntps_pkg::f_res(w_upd);
                        end
                        ntps_pkg::CMD_DEL: begin
                            if (r_par_v && r_par == r_p) begin
                                n_par_v = 1'b0;
                                n_par   = '0;
                            end else if (r_par_v && r_par > r_p) begin
                                n_par = r_par - 1'b1;
                            end
                            n_res = ntps_pkg::f_stat(ntps_pkg::ST_OK);
                            if (w_p1c < w_cntc) begin
                                n_state = S_DL_RD;
                            end else begin
                                n_cnt = r_cnt - 1'b1;
                            end
                        end
                        ntps_pkg::CMD_SEL: begin
                            n_par_v = 1'b1;
                            n_par   = r_p;
                            n_res   = ntps_pkg::f_res(i_rdata_a);
                        end
                        default: n_res = ntps_pkg::f_res(i_rdata_a);
                    endcase
                end else if (w_p1c < w_cntc) begin
                    n_p     = w_p1;
                    n_state = S_SC_RD;
                end else begin
                    n_state = S_DONE;
                    n_res   = ntps_pkg::f_stat(ntps_pkg::ST_MISS);
                    if (r_in.cmd == ntps_pkg::CMD_SEL) begin
                        n_par_v = 1'b0;
                        n_par   = '0;
                    end
                end
            end
            S_SO_RD: n_state = S_SO_CK;
            S_SO_CK: begin
                if (i_rdata_a.rank > i_rdata_b.rank) begin
                    o_we    = 1'b1;
                    o_wdata = i_rdata_b;
                    n_tmp   = i_rdata_a;
                    n_swap  = 1'b1;
                    if (r_par == r_p) begin
                        n_par = w_p1;
                    end else if (r_par == w_p1) begin
                        n_par = r_p;
                    end
                    n_state = S_SO_WR;
                end else begin
                    w_more = 1'b1;
                end
            end
            S_SO_WR: begin
                o_we    = 1'b1;
                o_waddr = w_p1;
                o_wdata = r_tmp;
                w_more  = 1'b1;
            end
            S_DL_RD: n_state = S_DL_WR;
            S_DL_WR: begin
                o_we = 1'b1;
                if (w_p2c < w_cntc) begin
                    n_p     = w_p1;
                    n_state = S_DL_RD;
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_PR_RD: n_state = S_PR_CK;
            S_PR_CK: begin
                n_res   = ntps_pkg::f_res(i_rdata_a);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // end of one compare step in a sort pass
        if (w_more) begin
            if (w_p2c < w_cntc) begin
                n_p     = w_p1;
                n_state = S_SO_RD;
            end else if (n_swap) begin
                n_p     = '0;
                n_swap  = 1'b0;
                n_state = S_SO_RD;
            end else begin
                n_p = '0;
                if (r_in.cmd == ntps_pkg::CMD_SEL) begin
                    n_state = S_SC_RD;
                end else begin
                    n_res   = ntps_pkg::f_stat(ntps_pkg::ST_OK);
                    n_state = S_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_par_v <= 1'b0;
            r_par   <= '0;
            r_p     <= '0;
            r_swap  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_par_v <= n_par_v;
            r_par   <= n_par;
            r_p     <= n_p;
            r_swap  <= n_swap;
        end
        r_in  <= n_in;
        r_res <= n_res;
        r_tmp <= n_tmp;
    end
endmodule

// ----- hw/rtl/neighbor_table_parent_select.sv -----
// Find/update/delete scan entries in list order (read, check); delete then shifts each later
// entry down (read, write). Add and select_parent on a table of n >= 2 entries run bubble-sort
// passes of n-1 compares (read, check, and a write pair on a swap), at most n passes, repeating
// while a pass swapped; select_parent then scans for its parent. Clear and get_parent need no scan;
// one item at a time. The scan shares its rank/address compare; sorting uses both read ports.
// Reset (synchronous, active low) empties the table through the fill count and drops the parent.
`timescale 1ns / 1ps
module neighbor_table_parent_select #(
    parameter int ENTRIES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ntps_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ntps_pkg::t_out  o_out_data
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic              w_take, w_done, w_we;
    logic [IW-1:0]     w_waddr, w_ra, w_rb;
    ntps_pkg::t_entry  w_wdata, w_rda, w_rdb;
    ntps_pkg::t_out    w_res;
    logic              r_out_valid;
    ntps_pkg::t_out    r_out;

    assign w_take = !r_out_valid || !i_out_stall;

    ntps_seq #(.ENTRIES(ENTRIES), .IW(IW), .CW(CW)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_stall(o_in_stall), .i_data(i_in_data),
        .i_take(w_take), .o_done(w_done), .o_res(w_res),
        .o_we(w_we), .o_waddr(w_waddr), .o_wdata(w_wdata),
        .o_raddr_a(w_ra), .o_raddr_b(w_rb), .i_rdata_a(w_rda), .i_rdata_b(w_rdb)
    );

    ntps_mem #(.ENTRIES(ENTRIES), .IW(IW)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr_a(w_ra), .i_raddr_b(w_rb), .o_rdata_a(w_rda), .o_rdata_b(w_rdb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_done) r_out <= w_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// ----- hw/rtl/ntps_chk.sv -----
// Port-level checks for the neighbor table, bound to the top level.
`timescale 1ns / 1ps
module ntps_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input ntps_pkg::t_out  o_out_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result item dropped or changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ntps_pkg::ST_OK ||
                         o_out_data.status == ntps_pkg::ST_MISS ||
                         o_out_data.status == ntps_pkg::ST_FULL))
        else $error("illegal status code");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ntps_pkg::ST_OK |->
        o_out_data.res_addr_hi == '0 && o_out_data.res_addr_lo == '0 &&
        o_out_data.res_rank == '0 && o_out_data.res_reachable == 1'b0)
        else $error("entry fields not zero on a failed command");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("new item taken before the previous one finished");
endmodule

bind neighbor_table_parent_select ntps_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
);

// ----- test/neighbor_table_parent_select_test.sv -----
// Testbench for the neighbor table with preferred-parent selection.
`timescale 1ns / 1ps
module neighbor_table_parent_select_test;

    localparam int N = 16;
    localparam int LIMIT = 4000000;
    // a command code the block does not define
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    class table_board;
        bit                v[N];
        ntps_pkg::t_entry  e[N];
        int                pos[N];
        bit                par_v;
        int                par_s;
        ntps_pkg::t_out    pend[$];
        int                errors;
        int                adds, sels, fulls;

        function void clear_all();
            foreach (v[i]) v[i] = 0;
            par_v = 0;
            par_s = 0;
        endfunction

        function void rank_sort();
            int np[N];
            int c;
            for (int i = 0; i < N; i++) begin
                c = 0;
                np[i] = 0;
                if (!v[i]) continue;
                for (int j = 0; j < N; j++) begin
                    if (!v[j] || j == i) continue;
                    if (e[j].rank < e[i].rank || (e[j].rank == e[i].rank && pos[j] < pos[i]))
                        c++;
                end
                np[i] = c;
            end
            for (int i = 0; i < N; i++) if (v[i]) pos[i] = np[i];
        endfunction

        function int match_addr(logic [63:0] hi, logic [63:0] lo);
            int b;
            b = N;
            for (int i = 0; i < N; i++)
                if (v[i] && e[i].addr_hi == hi && e[i].addr_lo == lo)
                    if (b == N || pos[i] < pos[b]) b = i;
            return b;
        endfunction

        function ntps_pkg::t_out entry_res(int s);
            ntps_pkg::t_out r;
            r.status = ntps_pkg::ST_OK;
            r.res_addr_hi = e[s].addr_hi;
            r.res_addr_lo = e[s].addr_lo;
            r.res_dodag_hi = e[s].dodag_hi;
            r.res_dodag_lo = e[s].dodag_lo;
            r.res_rank = e[s].rank;
            r.res_dtsn = e[s].dtsn;
            r.res_iface = e[s].iface;
            r.res_reachable = e[s].reach;
            return r;
        endfunction

        function void note_item(ntps_pkg::t_in x);
            ntps_pkg::t_out r;
            int s, n;
            r = '0;
            r.status = ntps_pkg::ST_MISS;
            case (x.cmd)
                ntps_pkg::CMD_ADD: begin
                    n = 0;
                    s = N;
                    for (int i = N - 1; i >= 0; i--) begin
                        if (v[i]) n++;
                        else s = i;
                    end
                    if (s == N) begin
                        r.status = ntps_pkg::ST_FULL;
                        fulls++;
                    end else begin
                        v[s] = 1;
                        e[s].addr_hi = x.addr_hi;
                        e[s].addr_lo = x.addr_lo;
                        e[s].dodag_hi = x.dodag_hi;
                        e[s].dodag_lo = x.dodag_lo;
                        e[s].rank = x.rank_in;
                        e[s].dtsn = x.dtsn_in;
                        e[s].iface = x.iface_in;
                        e[s].reach = x.reachable_in;
                        pos[s] = n;
                        rank_sort();
                        r.status = ntps_pkg::ST_OK;
                        adds++;
                    end
                end
                ntps_pkg::CMD_DEL: begin
                    s = match_addr(x.addr_hi, x.addr_lo);
                    if (s < N) begin
                        for (int i = 0; i < N; i++)
                            if (v[i] && i != s && pos[i] > pos[s]) pos[i]--;
                        v[s] = 0;
                        if (par_v && par_s == s) begin
                            par_v = 0;
                            par_s = 0;
                        end
                        r.status = ntps_pkg::ST_OK;
                    end
                end
                ntps_pkg::CMD_FIND: begin
                    s = match_addr(x.addr_hi, x.addr_lo);
                    if (s < N) r = entry_res(s);
                end
                ntps_pkg::CMD_UPD: begin
                    s = match_addr(x.addr_hi, x.addr_lo);
                    if (s < N) begin
                        e[s].dodag_hi = x.dodag_hi;
                        e[s].dodag_lo = x.dodag_lo;
                        e[s].rank = x.rank_in;
                        e[s].dtsn = x.dtsn_in;
                        e[s].iface = x.iface_in;
                        r = entry_res(s);
                    end
                end
                ntps_pkg::CMD_CLR: begin
                    clear_all();
                    r.status = ntps_pkg::ST_OK;
                end
                ntps_pkg::CMD_SEL: begin
                    rank_sort();
                    s = N;
                    for (int i = 0; i < N; i++)
                        if (v[i] && e[i].reach && e[i].rank < x.rank_in)
                            if (s == N || pos[i] < pos[s]) s = i;
                    if (s < N) begin
                        par_v = 1;
                        par_s = s;
                        r = entry_res(s);
                        sels++;
                    end else begin
                        par_v = 0;
                        par_s = 0;
                    end
                end
                ntps_pkg::CMD_GET: if (par_v && v[par_s]) r = entry_res(par_s);
                default: ;
            endcase
            pend = {pend, r};
        endfunction

        function void check_res(ntps_pkg::t_out a);
            ntps_pkg::t_out x;
            if (pend.size() == 0) begin
                $error("result with nothing expected: %p", a);
                errors++;
                return;
            end
            x = pend.pop_front();
            if (a.status !== x.status) begin
                $error("status exp %0d got %0d", x.status, a.status); errors++;
            end
            if (a.res_addr_hi !== x.res_addr_hi) begin
                $error("res_addr_hi exp %h got %h", x.res_addr_hi, a.res_addr_hi); errors++;
            end
            if (a.res_addr_lo !== x.res_addr_lo) begin
                $error("res_addr_lo exp %h got %h", x.res_addr_lo, a.res_addr_lo); errors++;
            end
            if (a.res_dodag_hi !== x.res_dodag_hi) begin
                $error("res_dodag_hi exp %h got %h", x.res_dodag_hi, a.res_dodag_hi);
                errors++;
            end
            if (a.res_dodag_lo !== x.res_dodag_lo) begin
                $error("res_dodag_lo exp %h got %h", x.res_dodag_lo, a.res_dodag_lo);
                errors++;
            end
            if (a.res_rank !== x.res_rank) begin
                $error("res_rank exp %0d got %0d", x.res_rank, a.res_rank); errors++;
            end
            if (a.res_dtsn !== x.res_dtsn) begin
                $error("res_dtsn exp %0d got %0d", x.res_dtsn, a.res_dtsn); errors++;
            end
            if (a.res_iface !== x.res_iface) begin
                $error("res_iface exp %0d got %0d", x.res_iface, a.res_iface); errors++;
            end
            if (a.res_reachable !== x.res_reachable) begin
                $error("res_reachable exp %0d got %0d", x.res_reachable, a.res_reachable);
                errors++;
            end
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    ntps_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_stall;
    ntps_pkg::t_out o_out_data;

    table_board board;
    int  cycles;
    bit  hold_out;
    bit  sending_done;
    int  hold_len;
    logic [63:0] addr_pool[8];

    neighbor_table_parent_select #(.ENTRIES(N)) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(ntps_pkg::t_in x);
        i_in_valid <= 1'b1;
        i_in_data <= x;
        do @(posedge i_clk); while (o_in_stall);
        board.note_item(x);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_cmd(logic [2:0] c, int ai, logic [15:0] rk, bit rch);
        ntps_pkg::t_in x;
        x.cmd = c;
        x.addr_hi = addr_pool[ai];
        x.addr_lo = ~addr_pool[ai] ^ 64'(ai);
        x.dodag_hi = rnd64();
        x.dodag_lo = rnd64();
        x.dtsn_in = 8'($urandom);
        x.rank_in = rk;
        x.iface_in = 8'($urandom);
        x.reachable_in = rch;
        send_item(x);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pend.size() != 0) @(posedge i_clk);
    endtask

    // Ranks cluster on a few values so ties and stable ordering come up often.
    function automatic logic [15:0] rnd_rank();
        int p;
        p = $urandom_range(0, 9);
        if (p < 5) return 16'($urandom_range(0, 7) * 256);
        if (p < 7) return (p == 5) ? 16'h0000 : 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic random_item();
        int p;
        logic [2:0] c;
        ntps_pkg::t_in x;
        p = $urandom_range(0, 99);
        if (p < 30) c = ntps_pkg::CMD_ADD;
        else if (p < 45) c = ntps_pkg::CMD_DEL;
        else if (p < 60) c = ntps_pkg::CMD_FIND;
        else if (p < 72) c = ntps_pkg::CMD_UPD;
        else if (p < 74) c = ntps_pkg::CMD_CLR;
        else if (p < 86) c = ntps_pkg::CMD_SEL;
        else if (p < 97) c = ntps_pkg::CMD_GET;
        else c = CMD_UNUSED;
        if ($urandom_range(0, 19) == 0) begin
            x.cmd = c;
            x.addr_hi = rnd64();
            x.addr_lo = rnd64();
            x.dodag_hi = rnd64();
            x.dodag_lo = rnd64();
            x.dtsn_in = 8'($urandom);
            x.rank_in = 16'($urandom);
            x.iface_in = 8'($urandom);
            x.reachable_in = 1'($urandom);
            send_item(x);
        end else begin
            send_cmd(c, $urandom_range(0, 7), rnd_rank(), $urandom_range(0, 3) != 0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("cycle limit reached, %0d results outstanding", board.pend.size());
            $display("neighbor_table_parent_select regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_res(o_out_data);
    end

    // Receiver stall: random gaps, plus one long hold requested by the sender.
    initial begin
        int n;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (1) begin
            if (hold_out) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_out = 0;
            end
            n = gap_len();
            i_out_stall <= (n > 0);
            repeat (n > 0 ? n : 1) @(posedge i_clk);
            if (!sending_done || $urandom_range(0, 1)) i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    initial begin
        int tail;
        board = new();
        board.clear_all();
        board.errors = 0;
        cycles = 0;
        hold_out = 0;
        sending_done = 0;
        hold_len = 0;
        foreach (addr_pool[i]) addr_pool[i] = rnd64();
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-table misses, extremes, duplicates, fill, parent cases.
        send_cmd(ntps_pkg::CMD_GET, 0, 16'h0, 1);
        send_cmd(ntps_pkg::CMD_FIND, 1, 16'h0, 1);
        send_cmd(ntps_pkg::CMD_SEL, 0, 16'hFFFF, 1);
        send_cmd(ntps_pkg::CMD_ADD, 0, 16'hFFFF, 1);
        send_cmd(ntps_pkg::CMD_ADD, 1, 16'h0000, 1);
        send_cmd(ntps_pkg::CMD_ADD, 2, 16'h0100, 0);
        send_cmd(ntps_pkg::CMD_ADD, 2, 16'h0100, 1);
        send_cmd(ntps_pkg::CMD_SEL, 0, 16'h0000, 1);
        send_cmd(ntps_pkg::CMD_SEL, 0, 16'hFFFF, 1);
        send_cmd(ntps_pkg::CMD_GET, 0, 16'h0, 0);
        send_cmd(ntps_pkg::CMD_UPD, 2, 16'h0000, 0);
        send_cmd(ntps_pkg::CMD_FIND, 2, 16'h0, 0);
        send_cmd(ntps_pkg::CMD_DEL, 1, 16'h0, 0);
        send_cmd(ntps_pkg::CMD_GET, 0, 16'h0, 0);
        send_cmd(ntps_pkg::CMD_DEL, 5, 16'h0, 0);
        for (int i = 0; i < 14; i++)
            send_cmd(ntps_pkg::CMD_ADD, i % 8, 16'($urandom_range(0, 3)), 1);
        send_cmd(ntps_pkg::CMD_ADD, 3, 16'h5, 1);
        send_cmd(CMD_UNUSED, 3, 16'h5, 1);
        send_cmd(ntps_pkg::CMD_SEL, 0, 16'h3, 1);
        send_cmd(ntps_pkg::CMD_CLR, 0, 16'h0, 0);
        send_cmd(ntps_pkg::CMD_GET, 0, 16'h0, 0);
        drain();

        // Receiver holds off long while items keep coming in.
        hold_len = 400;
        hold_out = 1;
        for (int i = 0; i < 40; i++) random_item();
        // Sender pauses until all results are back.
        drain();

        for (int i = 0; i < 1000; i++) begin
            random_item();
            idle_gap(gap_len());
        end
        sending_done = 1;
        drain();
        tail = 0;
        while (tail < 2000) begin
            @(posedge i_clk);
            tail++;
        end

        $display("%0d adds, %0d full answers, %0d parents picked; %0d cycles",
                 board.adds, board.fulls, board.sels, cycles);
        if (board.errors == 0 && board.pend.size() == 0)
            $display("neighbor_table_parent_select regression: pass");
        else
            $display("neighbor_table_parent_select regression: fail");
        $finish;
    end
endmodule
